### src/uchash_pkg.sv
`default_nettype none

package uchash_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] LastStep = 4'd9;

  localparam logic CfgDigestZero = 1'b0;
  localparam logic CfgDigestOne  = 1'b1;

  // multiplier constants per slot; first index is the word slot
  localparam logic [WordW-1:0] MulA [2][4] = '{
    '{32'hCF98B111, 32'h87085B9F, 32'h12CEB96D, 32'h257E1D83},
    '{32'hA27416F5, 32'hD38396FF, 32'h7C932B89, 32'hBFA49F69}
  };
  localparam logic [WordW-1:0] MulB [2][4] = '{
    '{32'hEF0569FB, 32'h689B6B9F, 32'h79F8A395, 32'hC3EFEA97},
    '{32'hC31713DB, 32'hDDCD1F0F, 32'h59C3AF2D, 32'h35BD1EC9}
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HOLD,
    OP_LATCH,
    OP_ADD,
    OP_MUL1,
    OP_MUL2,
    OP_MIX1,
    OP_MUL3,
    OP_MUL4,
    OP_MIX2,
    OP_MUL5,
    OP_FOLD,
    OP_TOTAL,
    OP_EMIT
  } uchash_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } uchash_state_e;

  typedef struct packed {
    uchash_op_e op;
    logic       slot;
    logic       block_done;
  } uchash_cmd_t;

  typedef struct packed {
    logic out_full;
  } uchash_sts_t;

  function automatic logic [WordW-1:0] swap16(input logic [WordW-1:0] x);
    return {x[15:0], x[31:16]};
  endfunction

  // one absorb of a word runs these ops in order
  function automatic uchash_op_e step_op(input logic [StepW-1:0] step);
    uchash_op_e op;
    unique case (step)
      4'd0:    op = OP_ADD;
      4'd1:    op = OP_MUL1;
      4'd2:    op = OP_MUL2;
      4'd3:    op = OP_MIX1;
      4'd4:    op = OP_MUL3;
      4'd5:    op = OP_MUL4;
      4'd6:    op = OP_MIX2;
      4'd7:    op = OP_MUL5;
      4'd8:    op = OP_FOLD;
      4'd9:    op = OP_TOTAL;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

### src/uchash_ctrl.sv
`default_nettype none

module uchash_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  input  wire                  s_axis_tlast_i,
  output logic                 s_axis_tready_o,
  input  uchash_pkg::uchash_sts_t sts_i,
  output uchash_pkg::uchash_cmd_t cmd_o
);
  import uchash_pkg::*;

  uchash_state_e    state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             slot_run_q, slot_run_d;
  logic             word_slot_q, word_slot_d;
  logic             block_done_q, block_done_d;
  logic             last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      slot_run_q   <= 1'b0;
      word_slot_q  <= 1'b0;
      block_done_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      slot_run_q   <= slot_run_d;
      word_slot_q  <= word_slot_d;
      block_done_q <= block_done_d;
      last_q       <= last_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    slot_run_d      = slot_run_q;
    word_slot_d     = word_slot_q;
    block_done_d    = block_done_q;
    last_d          = last_q;
    s_axis_tready_o = 1'b0;
    cmd_o.op         = OP_NONE;
    cmd_o.slot       = slot_run_q;
    cmd_o.block_done = block_done_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (!word_slot_q) begin
            cmd_o.op    = OP_HOLD;
            word_slot_d = 1'b1;
            if (s_axis_tlast_i) begin
              state_d = ST_EMIT;
            end
          end else begin
            cmd_o.op    = OP_LATCH;
            word_slot_d = 1'b0;
            last_d      = s_axis_tlast_i;
            slot_run_d  = 1'b0;
            step_d      = '0;
            state_d     = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.op = step_op(step_q);
        if (step_q == LastStep) begin
          step_d = '0;
          if (!slot_run_q) begin
            slot_run_d = 1'b1;
          end else begin
            block_done_d = 1'b1;
            state_d      = last_q ? ST_EMIT : ST_IDLE;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.op     = OP_EMIT;
          word_slot_d  = 1'b0;
          block_done_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStep)
    else $error("step counter out of range");

  a_block_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == LastStep && slot_run_q) |=> block_done_q)
    else $error("finished block not marked");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !sts_i.out_full)
      |=> (state_q == ST_IDLE && !word_slot_q && !block_done_q))
    else $error("message state not cleared after result");
`endif

endmodule

`default_nettype wire

### src/uchash_dp.sv
`default_nettype none

module uchash_dp (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire                     cfg_addr_i,
  input  wire  [31:0]             cfg_data_i,
  input  wire  [31:0]             s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  wire                     m_axis_tready_i,
  output logic [63:0]             m_axis_tdata_o,
  output logic                    m_axis_tuser_o,
  input  uchash_pkg::uchash_cmd_t cmd_i,
  output uchash_pkg::uchash_sts_t sts_o
);
  import uchash_pkg::*;

  logic [WordW-1:0] dig0_q, dig1_q;
  logic [WordW-1:0] sum_a_q, sum_b_q, tot_a_q, tot_b_q;
  logic [WordW-1:0] held_q, odd_q;
  logic [WordW-1:0] a_q, b_q, t_q, u_q;
  logic [WordW-1:0] hash_low_q, hash_high_q;
  logic             hash_valid_q;
  logic             out_valid_q;

  logic [WordW-1:0] first, word;
  logic [WordW-1:0] ax, ay, bx, by;
  logic [WordW-1:0] pa, pb;

  assign first = (cmd_i.slot ? dig1_q : dig0_q) | 32'd1;
  assign word  = cmd_i.slot ? odd_q : held_q;

  // two 32x32 multipliers, low half kept; results land in registers
  always_comb begin
    ax = '0;
    ay = '0;
    bx = '0;
    by = '0;
    unique case (cmd_i.op)
      OP_MUL1: begin
        ax = a_q;          ay = first;
        bx = swap16(b_q);  by = MulB[cmd_i.slot][0];
      end
      OP_MUL2: begin
        ax = swap16(a_q);  ay = MulA[cmd_i.slot][0];
        bx = b_q;          by = first;
      end
      OP_MIX1: begin
        ax = swap16(a_q);  ay = MulA[cmd_i.slot][1];
      end
      OP_MUL3: begin
        ax = swap16(a_q);  ay = MulA[cmd_i.slot][2];
        bx = {16'd0, b_q[31:16]};
        by = MulB[cmd_i.slot][1];
      end
      OP_MUL4: begin
        ax = swap16(a_q);  ay = MulA[cmd_i.slot][3];
        bx = b_q;          by = MulB[cmd_i.slot][2];
      end
      OP_MUL5: begin
        bx = swap16(b_q);  by = MulB[cmd_i.slot][3];
      end
      default: begin
      end
    endcase
  end

  assign pa = ax * ay;
  assign pb = bx * by;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig0_q      <= '0;
      dig1_q      <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      tot_a_q     <= '0;
      tot_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgDigestZero: dig0_q <= cfg_data_i;
          CfgDigestOne:  dig1_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_FOLD: begin
          sum_a_q <= a_q;
          sum_b_q <= t_q + b_q;
          tot_a_q <= tot_a_q + a_q;
        end
        OP_TOTAL: tot_b_q <= tot_b_q + sum_b_q;
        OP_EMIT: begin
          sum_a_q <= '0;
          sum_b_q <= '0;
          tot_a_q <= '0;
          tot_b_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_HOLD:  held_q <= s_axis_tdata_i;
      OP_LATCH: odd_q  <= s_axis_tdata_i;
      OP_ADD: begin
        a_q <= sum_a_q + word;
        b_q <= sum_b_q + word;
      end
      OP_MUL1: begin
        a_q <= pa;
        t_q <= pb;
      end
      OP_MUL2: begin
        a_q <= pa;
        u_q <= pb;
      end
      OP_MIX1: begin
        a_q <= pa;
        b_q <= t_q + u_q;
      end
      OP_MUL3: begin
        a_q <= pa;
        t_q <= pb;
      end
      OP_MUL4: begin
        a_q <= pa;
        u_q <= pb;
      end
      OP_MIX2: b_q <= t_q + u_q;
      OP_MUL5: t_q <= pb;
      OP_EMIT: begin
        hash_valid_q <= cmd_i.block_done;
        hash_low_q   <= cmd_i.block_done ? (sum_a_q ^ sum_b_q) : '0;
        hash_high_q  <= cmd_i.block_done ? (tot_a_q ^ tot_b_q) : '0;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.out_full  = out_valid_q && !m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {hash_high_q, hash_low_q};
  assign m_axis_tuser_o  = hash_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> !(out_valid_q && !m_axis_tready_i))
    else $error("result overwritten before it was taken");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !hash_valid_q) |-> (hash_low_q == '0 && hash_high_q == '0))
    else $error("empty message result not zero");
`endif

endmodule

`default_nettype wire

### src/user_choice_word_hash_core.sv
// Two-checksum word hash over a message streamed as 32-bit words.
// Input stream: s_axis_tdata_i carries one little-endian message word,
// s_axis_tlast_i marks the final word. Words pair into 8-byte blocks; an
// even word is held until its odd partner arrives, and a trailing unpaired
// word is dropped. Output stream: one word per message, sent after the
// last input word, with tdata = {hash_high, hash_low} and tuser = hash_valid
// (0 when no complete block arrived, with both hashes zero).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_addr_i
// (0: digest word zero, 1: digest word one). Write only while idle.
// Sequencing: an even word is held on accept. An odd word then runs 10
// sequencer steps per word slot, set by the chain of dependent products
// on the two shared 32x32 multipliers; input is not ready meanwhile. The
// result is emitted after the block finishes or after an even last word.
// A stalled result stays in the output register; the block keeps accepting
// words meanwhile and only waits if a second result is ready before the first
// is taken. Reset clears checksums, totals, configuration and the output.
`default_nettype none

module user_choice_word_hash_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_addr_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,  // [31:0] data_word
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // [31:0] hash_low, [63:32] hash_high
  output logic        m_axis_tuser_o   // [0] hash_valid
);
  import uchash_pkg::*;

  uchash_cmd_t cmd;
  uchash_sts_t sts;

  uchash_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  uchash_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

### tb/user_choice_word_hash_core_test.sv
`default_nettype none

module user_choice_word_hash_core_test;
  import uchash_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;  // settle time after an odd word and its emit
  localparam int unsigned WORD_TARGET = 750;

  // scramble chain multipliers, first index is the word slot
  localparam logic [31:0] CHAIN_A [2][4] = '{
    '{32'hCF98B111, 32'h87085B9F, 32'h12CEB96D, 32'h257E1D83},
    '{32'hA27416F5, 32'hD38396FF, 32'h7C932B89, 32'hBFA49F69}
  };
  localparam logic [31:0] CHAIN_B [2][4] = '{
    '{32'hEF0569FB, 32'h689B6B9F, 32'h79F8A395, 32'hC3EFEA97},
    '{32'hC31713DB, 32'hDDCD1F0F, 32'h59C3AF2D, 32'h35BD1EC9}
  };

  typedef struct packed {
    logic        valid;
    logic [31:0] high;
    logic [31:0] low;
  } msg_hash_t;

  class hash_scoreboard;
    logic [31:0] digest_even, digest_odd;
    logic [31:0] sum_a, sum_b, total_a, total_b;
    logic [31:0] held_word;
    logic        odd_slot, have_block;
    msg_hash_t   hash_q[$];
    int          errors;

    function new();
      digest_even = '0;
      digest_odd  = '0;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      sum_a      = '0;
      sum_b      = '0;
      total_a    = '0;
      total_b    = '0;
      held_word  = '0;
      odd_slot   = 1'b0;
      have_block = 1'b0;
    endfunction

    function void set_digest(logic idx, logic [31:0] value);
      if (idx == CfgDigestZero) digest_even = value;
      else digest_odd = value;
    endfunction

    function logic [31:0] rot16(logic [31:0] x);
      return {x[15:0], x[31:16]};
    endfunction

    function void mix_word(logic [31:0] word, int slot);
      logic [31:0] first, a, b;
      first = (slot != 0 ? digest_odd : digest_even) | 32'h1;
      a = sum_a + word;
      b = sum_b + word;
      a = a * first;
      a = rot16(a) * CHAIN_A[slot][0];
      a = rot16(a) * CHAIN_A[slot][1];
      a = rot16(a) * CHAIN_A[slot][2];
      a = rot16(a) * CHAIN_A[slot][3];
      sum_a   = a;
      total_a = total_a + a;
      b = rot16(b) * CHAIN_B[slot][0] + b * first;
      b = (b >> 16) * CHAIN_B[slot][1] + b * CHAIN_B[slot][2];
      b = rot16(b) * CHAIN_B[slot][3] + b;
      sum_b   = b;
      total_b = total_b + b;
    endfunction

    function void note_word(logic [31:0] word, logic last);
      msg_hash_t h;
      if (!odd_slot) begin
        held_word = word;
        odd_slot  = 1'b1;
      end else begin
        mix_word(held_word, 0);
        mix_word(word, 1);
        have_block = 1'b1;
        odd_slot   = 1'b0;
      end
      if (last) begin
        h.valid = have_block;
        h.low   = have_block ? (sum_a ^ sum_b) : '0;
        h.high  = have_block ? (total_a ^ total_b) : '0;
        hash_q.push_back(h);
        restart();
      end
    endfunction

    function void check_word(logic [63:0] data, logic user);
      msg_hash_t want;
      if (hash_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: tdata=%h tuser=%b", $time, data, user);
        return;
      end
      want = hash_q.pop_front();
      if (data[31:0] !== want.low) begin
        errors++;
        $display("%0t: hash_low exp %h got %h", $time, want.low, data[31:0]);
      end
      if (data[63:32] !== want.high) begin
        errors++;
        $display("%0t: hash_high exp %h got %h", $time, want.high, data[63:32]);
      end
      if (user !== want.valid) begin
        errors++;
        $display("%0t: hash_valid exp %b got %b", $time, want.valid, user);
      end
    endfunction

    function int pending();
      return hash_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] data_word
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;   // [31:0] hash_low, [63:32] hash_high
  logic        m_axis_tuser_o;   // [0] hash_valid

  hash_scoreboard board = new();
  int unsigned    cycle_count = 0;
  int unsigned    words_sent = 0;
  logic           tx_burst = 1'b0;
  logic           rx_burst = 1'b0;

  user_choice_word_hash_core DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] word, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_word(word, last);
    words_sent++;
  endtask

  task automatic send_message(input logic [31:0] words[$]);
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  // drop valid and hold off until every pending hash has been taken
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_digests(input logic [31:0] even_word, input logic [31:0] odd_word);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CfgDigestZero;
    cfg_data_i <= even_word;
    @(posedge clk_i);
    board.set_digest(CfgDigestZero, even_word);
    cfg_addr_i <= CfgDigestOne;
    cfg_data_i <= odd_word;
    @(posedge clk_i);
    board.set_digest(CfgDigestOne, odd_word);
    cfg_we_i <= 1'b0;
  endtask

  // result side
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_word(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin
    logic [31:0] words[$];
    int          len;
    int          phase;
    logic [31:0] w;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= CfgDigestZero;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    m_axis_tready_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset digests: lone last word, one block, dropped trailing word, two blocks
    words = '{32'h00000000};
    send_message(words);
    words = '{32'hFFFFFFFF, 32'hFFFFFFFF};
    send_message(words);
    words = '{32'h00000000, 32'hFFFFFFFF, 32'h12345678};
    send_message(words);
    words = '{32'hA5A5A5A5, 32'h5A5A5A5A, 32'h00000000, 32'hFFFFFFFF};
    send_message(words);

    write_digests(32'hFFFFFFFF, 32'h00000000);
    words = '{32'hFFFFFFFF};
    send_message(words);
    words = '{32'h00000000, 32'h00000000};
    send_message(words);
    words = '{32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'hFFFFFFFE, 32'hDEADBEEF};
    send_message(words);
    words = '{32'hFFFFFFFF, 32'h00000000};
    send_message(words);

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= 20 + 120 * phase) begin
        case (phase % 5)
          0: write_digests(32'h00000000, 32'hFFFFFFFF);
          2: write_digests(32'hFFFFFFFE, 32'h00000001);
          4: write_digests(32'h80000000, 32'h7FFFFFFF);
          default: write_digests($urandom(), $urandom());
        endcase
        phase++;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      words.delete();
      repeat (len) begin
        case ($urandom_range(0, 9))
          0: w = 32'h00000000;
          1: w = 32'hFFFFFFFF;
          default: w = $urandom();
        endcase
        words.push_back(w);
      end
      send_message(words);
      if ($urandom_range(0, 14) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/uchash_pkg.sv
src/uchash_ctrl.sv
src/uchash_dp.sv
src/user_choice_word_hash_core.sv
tb/user_choice_word_hash_core_test.sv
